// ===== rtl/core/rls_pkg.sv =====
package rls_pkg;

    localparam int DIVIDEND_W  = 16;
    localparam int DIVISOR_W   = 3;
    localparam int HEAD_W      = 4;
    localparam int BUTTON_COUNT = 3;
    localparam int TABLE_LEN   = 12;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_BUTTON = 2'd1;
    localparam logic [1:0] CMD_RX     = 2'd2;

    localparam logic [1:0] BTN_START = 2'd0;
    localparam logic [1:0] BTN_PAUSE = 2'd1;
    localparam logic [1:0] BTN_DIR   = 2'd2;

    localparam logic [1:0] REG_BASE     = 2'd0;
    localparam logic [1:0] REG_ON       = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE = 2'd2;

    localparam logic [15:0] BASE_RESET     = 16'd2000;
    localparam logic [9:0]  ON_RESET       = 10'd20;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd250;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIVIDE,
        ST_PERIOD,
        ST_ADVANCE,
        ST_FINISH
    } rls_state_t;

    function automatic logic [7:0] seg_frame(input logic [HEAD_W-1:0] head);
        logic [7:0] seg;
        case (head)
            4'd0:    seg = 8'h01;
            4'd1:    seg = 8'h02;
            4'd2:    seg = 8'h04;
            4'd3:    seg = 8'h08;
            4'd4:    seg = 8'h08;
            4'd5:    seg = 8'h08;
            4'd6:    seg = 8'h08;
            4'd7:    seg = 8'h04;
            4'd8:    seg = 8'h02;
            4'd9:    seg = 8'h01;
            4'd10:   seg = 8'h01;
            4'd11:   seg = 8'h01;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    function automatic logic [7:0] mask_frame(input logic [HEAD_W-1:0] head);
        logic [7:0] mask;
        case (head)
            4'd0:    mask = 8'hFE;
            4'd1:    mask = 8'hFE;
            4'd2:    mask = 8'hFE;
            4'd3:    mask = 8'hFE;
            4'd4:    mask = 8'hFD;
            4'd5:    mask = 8'hFB;
            4'd6:    mask = 8'hF7;
            4'd7:    mask = 8'hF7;
            4'd8:    mask = 8'hF7;
            4'd9:    mask = 8'hF7;
            4'd10:   mask = 8'hEF;
            4'd11:   mask = 8'hDF;
            default: mask = 8'hFF;
        endcase
        return mask;
    endfunction

endpackage

// ===== rtl/core/running_light_sequencer.sv =====
// an accepted item passes through the decode and finish states; a tick while
//   running and not paused also passes through divide, period and advance,
//   waiting in divide on the 16-step shared restoring divider
// a finished result waits in the output register while the next item is taken
// reset: asynchronous active low, clears control state and loads register defaults
module running_light_sequencer
    import rls_pkg::*;
#(
    parameter int STEPS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // button_id[1:0], rx_byte[9:2], zero pad
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // segment_bits[7:0], digit_mask[15:8], position[19:16], is_running[20],
    // is_paused[21], is_forward[22], speed_level[25:23], advanced[26], zero pad
    output logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rls_state_t state_reg, state_next;

    logic [15:0] base_reg;
    logic [9:0]  on_reg;
    logic [15:0] debounce_reg;

    logic [1:0]  cmd_reg;
    logic [1:0]  btn_reg;
    logic [7:0]  rx_reg;

    logic [31:0]       ms_clock_reg;
    logic [31:0]       press_time_reg [BUTTON_COUNT];
    logic [HEAD_W-1:0] head_reg;
    logic              run_reg;
    logic              pause_reg;
    logic              forward_reg;
    logic [2:0]        speed_reg;
    logic [15:0]       step_timer_reg;
    logic [15:0]       period_reg;
    logic              adv_reg;

    logic        m_valid_reg;
    logic [31:0] m_data_reg;

    logic        div_start;
    logic        div_done;
    logic [15:0] div_quo;
    logic        out_load;

    logic              cfg_write;
    logic [31:0]       since_press;
    logic              press_ok;
    logic [16:0]       timer_inc;
    logic [15:0]       period_raw;
    logic [HEAD_W:0]   head_inc;
    logic [HEAD_W-1:0] head_moved;

    rls_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (base_reg),
        .divisor  (speed_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            REG_BASE:     prdata = {16'd0, base_reg};
            REG_ON:       prdata = {22'd0, on_reg};
            REG_DEBOUNCE: prdata = {16'd0, debounce_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= BASE_RESET;
            on_reg       <= ON_RESET;
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_BASE:     base_reg     <= pwdata[15:0];
                REG_ON:       on_reg       <= pwdata[9:0];
                REG_DEBOUNCE: debounce_reg <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_DECODE;
            ST_DECODE:  state_next = div_start ? ST_DIVIDE : ST_FINISH;
            ST_DIVIDE:  if (div_done) state_next = ST_PERIOD;
            ST_PERIOD:  state_next = ST_ADVANCE;
            ST_ADVANCE: state_next = ST_FINISH;
            ST_FINISH:  if (out_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_DECODE) && (cmd_reg == CMD_TICK) && run_reg && !pause_reg;
        out_load  = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath helpers
    assign since_press = ms_clock_reg - press_time_reg[btn_reg];
    assign press_ok    = (btn_reg != BTN_DIR + 2'd1) && (since_press >= {16'd0, debounce_reg});
    assign timer_inc   = {1'b0, step_timer_reg} + 17'd1;
    assign period_raw  = (div_quo > {6'd0, on_reg}) ? div_quo - {6'd0, on_reg} : {6'd0, on_reg};
    assign head_inc    = {1'b0, head_reg} + 1'b1;

    always_comb
    begin
        if (forward_reg)
            head_moved = (head_inc >= (HEAD_W+1)'(STEPS)) ? '0 : head_inc[HEAD_W-1:0];
        else
            head_moved = (head_reg == '0) ? HEAD_W'(STEPS - 1) : head_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser;
            btn_reg <= s_tdata[1:0];
            rx_reg  <= s_tdata[9:2];
        end
        if (state_reg == ST_PERIOD)
            period_reg <= (period_raw == '0) ? 16'd1 : period_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_clock_reg   <= '0;
            for (int i = 0; i < BUTTON_COUNT; i++)
                press_time_reg[i] <= '0;
            head_reg       <= '0;
            run_reg        <= 1'b0;
            pause_reg      <= 1'b0;
            forward_reg    <= 1'b1;
            speed_reg      <= 3'd1;
            step_timer_reg <= '0;
            adv_reg        <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_DECODE:
                begin
                    adv_reg <= 1'b0;
                    case (cmd_reg)
                        CMD_TICK:
                            ms_clock_reg <= ms_clock_reg + 32'd1;
                        CMD_BUTTON:
                        begin
                            if (press_ok)
                            begin
                                press_time_reg[btn_reg] <= ms_clock_reg;
                                case (btn_reg)
                                    BTN_START:
                                    begin
                                        if (run_reg)
                                        begin
                                            run_reg        <= 1'b0;
                                            pause_reg      <= 1'b0;
                                            head_reg       <= '0;
                                            step_timer_reg <= '0;
                                        end
                                        else
                                        begin
                                            run_reg <= 1'b1;
                                        end
                                    end
                                    BTN_PAUSE:
                                        if (run_reg) pause_reg <= !pause_reg;
                                    BTN_DIR:
                                        forward_reg <= !forward_reg;
                                    default: ;
                                endcase
                            end
                        end
                        CMD_RX:
                        begin
                            if (rx_reg >= 8'h31 && rx_reg <= 8'h35)
                                speed_reg <= 3'(rx_reg - 8'h30);
                            else if (rx_reg >= 8'h01 && rx_reg <= 8'h05)
                                speed_reg <= rx_reg[2:0];
                        end
                        default: ;
                    endcase
                end
                ST_ADVANCE:
                begin
                    if (timer_inc >= {1'b0, period_reg})
                    begin
                        head_reg       <= head_moved;
                        adv_reg        <= 1'b1;
                        step_timer_reg <= '0;
                    end
                    else
                    begin
                        step_timer_reg <= timer_inc[15:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_data_reg <= {5'd0, adv_reg, speed_reg, forward_reg, pause_reg, run_reg,
                           HEAD_W'(head_reg + 1'b1), mask_frame(head_reg), seg_frame(head_reg)};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, head_reg} < (HEAD_W+1)'(STEPS))
        else $error("head beyond step count");

    a_pause_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        pause_reg |-> run_reg)
        else $error("paused while stopped");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        speed_reg >= 3'd1 && speed_reg <= 3'd5)
        else $error("speed out of range");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVIDE)
        else $error("divider result outside divide state");

    a_adv_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && adv_reg |-> cmd_reg == CMD_TICK)
        else $error("head moved on a non-tick item");

endmodule

// ===== rtl/core/rls_divider.sv =====
module rls_divider
    import rls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_sub;
    logic                  fits;

    // one restoring step per cycle, quotient bits shift in from the right
    assign trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits      = trial >= {1'b0, divisor};
    assign trial_sub = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(DIVIDEND_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
